// File: hw/rtl/catmull_rom_stroke_smoother_unit_assert.svh
`ifndef CATMULL_ROM_STROKE_SMOOTHER_UNIT_ASSERT_SVH
`define CATMULL_ROM_STROKE_SMOOTHER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CRSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CRSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/crss_pkg.sv
package crss_pkg;

  localparam int COORD_W  = 12;
  localparam int OUT_W    = 22;
  localparam int SEG_LOG2 = 3;
  localparam int SEGMENTS = 1 << SEG_LOG2;

  // Curve numerator is scaled by 2*SEGMENTS^3.
  localparam int SH    = 3 * SEG_LOG2;
  localparam int ACC_W = SH + 17;
  localparam int RND_W = ACC_W + 9;
  localparam logic signed [RND_W-1:0] ROUND_BIAS = RND_W'(64'd1 << SH);

  localparam int CNT_W = (SEG_LOG2 > 0) ? SEG_LOG2 : 1;
  localparam logic [CNT_W-1:0] REM_FULL = CNT_W'(SEGMENTS - 1);

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] d1;
    logic signed [ACC_W-1:0] d2;
    logic signed [ACC_W-1:0] d3;
  } coef_t;

  typedef struct packed {
    coef_t cx;
    coef_t cy;
    logic  single;
    logic  last;
    logic  done;
  } entry_t;

  // Forward-difference start values for one segment, j = 1 preloaded.
  function automatic coef_t seg_coef(input logic [COORD_W-1:0] p0, input logic [COORD_W-1:0] p1,
                                     input logic [COORD_W-1:0] p2, input logic [COORD_W-1:0] p3);
    logic signed [ACC_W-1:0] e0, e1, e2, e3;
    logic signed [ACC_W-1:0] a, b, d, t, b6, n0, q1, q2;
    coef_t r;
    e0 = ACC_W'(p0);
    e1 = ACC_W'(p1);
    e2 = ACC_W'(p2);
    e3 = ACC_W'(p3);
    a  = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
    t  = e1 - e2;
    b  = (t <<< 1) + t + e3 - e0;
    d  = e2 - e0;
    b6 = (b <<< 2) + (b <<< 1);
    n0 = e1 <<< (SH + 1);
    q1 = (d <<< (2 * SEG_LOG2)) + (a <<< SEG_LOG2) + b;
    q2 = (a <<< (SEG_LOG2 + 1)) + b6;
    r.acc = n0 + q1;
    r.d1  = q1 + q2;
    r.d2  = q2 + b6;
    r.d3  = b6;
    return r;
  endfunction

  // Plain point: numerator 2*p*SEGMENTS^3 rounds back to p*256.
  function automatic coef_t pass_coef(input logic [COORD_W-1:0] p);
    coef_t r;
    r.acc = ACC_W'(p) <<< (SH + 1);
    r.d1  = '0;
    r.d2  = '0;
    r.d3  = '0;
    return r;
  endfunction

  // floor((256*n + S^3) / (2*S^3))
  function automatic logic signed [OUT_W-1:0] round_out(input logic signed [ACC_W-1:0] n);
    logic signed [RND_W-1:0] t;
    t = (RND_W'(n) <<< 8) + ROUND_BIAS;
    return OUT_W'(t >>> (SH + 1));
  endfunction

endpackage

// File: hw/rtl/crss_queue.sv
`include "catmull_rom_stroke_smoother_unit_assert.svh"

module crss_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  crss_pkg::entry_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output crss_pkg::entry_t head_o
);
  import crss_pkg::*;

  entry_t         mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QAW + 1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `CRSS_ASSERT_NOW(a_no_overflow, push_i, !full_o, "queue push while full")
  `CRSS_ASSERT_NOW(a_no_underflow, pop_i, !empty_o, "queue pop while empty")
  `CRSS_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= (QAW + 1)'(QDEPTH), "queue count out of range")

endmodule

// File: hw/rtl/crss_front.sv
`include "catmull_rom_stroke_smoother_unit_assert.svh"

module crss_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [crss_pkg::COORD_W-1:0]  pos_x_i,
  input  logic [crss_pkg::COORD_W-1:0]  pos_y_i,
  input  logic                          stroke_end_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output crss_pkg::entry_t              push_data_o
);
  import crss_pkg::*;

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;
  localparam logic [1:0] SEEN_FULL = 2'd3;

  logic [COORD_W-1:0] win_x_q [3];
  logic [COORD_W-1:0] win_y_q [3];
  logic [1:0]         seen_q, seen_d;
  logic               pend_q, pend_d;
  logic               accept;
  logic               single, last, done;
  logic [COORD_W-1:0] px [4];
  logic [COORD_W-1:0] py [4];

  // The final segment of a stroke is pushed from pend_q after its item, once the queue has room.
  assign in_stall_o = pend_q || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    push_o = 1'b0;
    single = 1'b0;
    last   = 1'b0;
    done   = 1'b0;
    px[0] = win_x_q[0]; px[1] = win_x_q[1]; px[2] = win_x_q[2]; px[3] = win_x_q[2];
    py[0] = win_y_q[0]; py[1] = win_y_q[1]; py[2] = win_y_q[2]; py[3] = win_y_q[2];
    if (pend_q) begin
      push_o = !q_full_i;
      last   = 1'b1;
      done   = 1'b1;
    end else if (accept) begin
      unique case (seen_q)
        SEEN_NONE: begin
          push_o = 1'b1;
          single = 1'b1;
          last   = 1'b1;
          done   = stroke_end_i;
          px[1]  = pos_x_i;
          py[1]  = pos_y_i;
        end
        SEEN_ONE: begin
          push_o = stroke_end_i;
          last   = 1'b1;
          done   = 1'b1;
          px[0] = win_x_q[2]; px[1] = win_x_q[2]; px[2] = pos_x_i; px[3] = pos_x_i;
          py[0] = win_y_q[2]; py[1] = win_y_q[2]; py[2] = pos_y_i; py[3] = pos_y_i;
        end
        SEEN_TWO, SEEN_FULL: begin
          push_o = 1'b1;
          last   = !stroke_end_i;
          // Clamp the leading neighbor while only two points are held.
          px[0] = (seen_q == SEEN_TWO) ? win_x_q[1] : win_x_q[0];
          py[0] = (seen_q == SEEN_TWO) ? win_y_q[1] : win_y_q[0];
          px[1] = win_x_q[1]; px[2] = win_x_q[2]; px[3] = pos_x_i;
          py[1] = win_y_q[1]; py[2] = win_y_q[2]; py[3] = pos_y_i;
        end
        default: begin
          push_o = 1'b0;
        end
      endcase
    end
  end

  assign push_data_o.cx     = single ? pass_coef(px[1]) : seg_coef(px[0], px[1], px[2], px[3]);
  assign push_data_o.cy     = single ? pass_coef(py[1]) : seg_coef(py[0], py[1], py[2], py[3]);
  assign push_data_o.single = single;
  assign push_data_o.last   = last;
  assign push_data_o.done   = done;

  always_comb begin
    seen_d = seen_q;
    pend_d = pend_q;
    if (pend_q && !q_full_i) begin
      pend_d = 1'b0;
    end
    if (accept) begin
      if (stroke_end_i) begin
        seen_d = SEEN_NONE;
      end else if (seen_q != SEEN_FULL) begin
        seen_d = seen_q + 1'b1;
      end
      pend_d = stroke_end_i && (seen_q == SEEN_TWO || seen_q == SEEN_FULL);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= SEEN_NONE;
      pend_q <= 1'b0;
    end else begin
      seen_q <= seen_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_x_q[0] <= win_x_q[1];
      win_x_q[1] <= win_x_q[2];
      win_x_q[2] <= pos_x_i;
      win_y_q[0] <= win_y_q[1];
      win_y_q[1] <= win_y_q[2];
      win_y_q[2] <= pos_y_i;
    end
  end

  `CRSS_ASSERT_NEXT(a_pend_cleared, accept && stroke_end_i, seen_q == SEEN_NONE,
                    "stroke end did not restart the point count")
  `CRSS_ASSERT_NEXT(a_pend_drains, pend_q && !q_full_i, !pend_q,
                    "final segment not released")

endmodule

// File: hw/rtl/crss_back.sv
`include "catmull_rom_stroke_smoother_unit_assert.svh"

module crss_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_empty_i,
  input  crss_pkg::entry_t                   q_head_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [crss_pkg::OUT_W-1:0]  curve_x_o,
  output logic signed [crss_pkg::OUT_W-1:0]  curve_y_o,
  output logic                               last_of_run_o,
  output logic                               stroke_done_o
);
  import crss_pkg::*;

  logic                busy_q;
  logic [CNT_W-1:0]    rem_q;
  coef_t               cx_q, cy_q;
  logic                last_q, done_q;
  logic                out_valid_q;
  logic signed [OUT_W-1:0] out_x_q, out_y_q;
  logic                out_last_q, out_done_q;
  logic                out_free, step, fin, load;

  assign out_free = !out_valid_q || !out_stall_i;
  assign step     = busy_q && out_free;
  assign fin      = step && (rem_q == '0);
  // Load the next segment in the cycle the current one ends.
  assign load     = !q_empty_i && (!busy_q || fin);
  assign pop_o    = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        rem_q  <= q_head_i.single ? '0 : REM_FULL;
      end else if (fin) begin
        busy_q <= 1'b0;
      end else if (step) begin
        rem_q <= rem_q - 1'b1;
      end
      if (out_free) begin
        out_valid_q <= step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cx_q   <= q_head_i.cx;
      cy_q   <= q_head_i.cy;
      last_q <= q_head_i.last;
      done_q <= q_head_i.done;
    end else if (step) begin
      // Advance the cubic by one forward difference.
      cx_q.acc <= cx_q.acc + cx_q.d1;
      cx_q.d1  <= cx_q.d1 + cx_q.d2;
      cx_q.d2  <= cx_q.d2 + cx_q.d3;
      cy_q.acc <= cy_q.acc + cy_q.d1;
      cy_q.d1  <= cy_q.d1 + cy_q.d2;
      cy_q.d2  <= cy_q.d2 + cy_q.d3;
    end
    if (step) begin
      out_x_q    <= round_out(cx_q.acc);
      out_y_q    <= round_out(cy_q.acc);
      out_last_q <= last_q && (rem_q == '0);
      out_done_q <= done_q && (rem_q == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign curve_x_o     = out_x_q;
  assign curve_y_o     = out_y_q;
  assign last_of_run_o = out_last_q;
  assign stroke_done_o = out_done_q;

  `CRSS_ASSERT_NOW(a_done_is_last, out_valid_q && out_done_q, out_last_q,
                   "stroke end flagged on a result that does not end its item")
  `CRSS_ASSERT_NEXT(a_segment_continues, step && (rem_q != '0), busy_q,
                    "segment dropped before its last point")

endmodule

// File: hw/rtl/catmull_rom_stroke_smoother_unit.sv
// Stroke smoother: uniform Catmull-Rom tessellation of a stream of control points.
// Input channel: one control point per item (pos_x_i, pos_y_i in whole pixels,
// stroke_end_i on the last point of a stroke), taken when in_valid_i is high
// and in_stall_o is low. Output channel: one curve point per item, signed fixed
// point with 8 fraction bits, taken when out_valid_o is high and out_stall_i low.
// The first point of a stroke comes back as one result; a second point gives
// none unless it ends the stroke, when it yields SEGMENTS (8) results for its
// segment; each later point yields SEGMENTS for the segment two points back, and
// the end point adds SEGMENTS more for the closing segment. last_of_run_o marks
// the last result of an item, stroke_done_o the last result of a stroke.
// Throughput: one result per cycle while out_stall_i is low, made by the
// forward-difference unit in the back end; points that give no result are taken
// every cycle while the 4-entry segment queue has room and no closing segment
// is pending; a stroke end holds the input until its closing segment is queued.
// When out_stall_i is high the output register holds its result, the back end
// waits, the queue fills and in_stall_o then rises.
// Reset clears the point count, the queue and the output valid; the next item
// after reset starts a new stroke.
module catmull_rom_stroke_smoother_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [crss_pkg::COORD_W-1:0]       pos_x_i,
  input  logic [crss_pkg::COORD_W-1:0]       pos_y_i,
  input  logic                               stroke_end_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [crss_pkg::OUT_W-1:0]  curve_x_o,
  output logic signed [crss_pkg::OUT_W-1:0]  curve_y_o,
  output logic                               last_of_run_o,
  output logic                               stroke_done_o
);
  import crss_pkg::*;

  logic   q_full, q_empty, q_push, q_pop;
  entry_t q_wdata, q_head;

  crss_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .stroke_end_i (stroke_end_i),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .push_data_o  (q_wdata)
  );

  crss_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  crss_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_head_i      (q_head),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .curve_x_o     (curve_x_o),
    .curve_y_o     (curve_y_o),
    .last_of_run_o (last_of_run_o),
    .stroke_done_o (stroke_done_o)
  );

endmodule
